// File: rtl/unique_key_linked_list_assert.svh
// ----------------------------------------------------------------------------
// unique_key_linked_list_assert.svh
// Assertion macros used by the list datapath module
// ----------------------------------------------------------------------------
`ifndef UNIQUE_KEY_LINKED_LIST_ASSERT_SVH
`define UNIQUE_KEY_LINKED_LIST_ASSERT_SVH

// same-cycle implication, checked outside reset
`define UKLL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define UKLL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ukll_pkg.sv
// ----------------------------------------------------------------------------
// ukll_pkg
// Shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package ukll_pkg;

    // node store size and derived widths
    localparam int CAPACITY = 16;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 3;

    typedef logic [SLOT_W-1:0]       slot_t;
    typedef logic [CNT_W-1:0]        count_t;
    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [OP_W-1:0]         op_t;
    typedef logic [STAT_W-1:0]       status_t;

    // command codes
    localparam op_t OP_INS_HEAD   = 3'd0;
    localparam op_t OP_INS_TAIL   = 3'd1;
    localparam op_t OP_INS_AFTER  = 3'd2;
    localparam op_t OP_INS_BEFORE = 3'd3;
    localparam op_t OP_DELETE     = 3'd4;
    localparam op_t OP_READ       = 3'd5;

    // result status codes
    localparam status_t ST_DONE   = 3'd0;
    localparam status_t ST_DUP    = 3'd1;
    localparam status_t ST_ABSENT = 3'd2;
    localparam status_t ST_FULL   = 3'd3;
    localparam status_t ST_EMPTY  = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic    load;        // capture the incoming item
        logic    walk_start;  // point the walker at the head
        logic    walk_step;   // advance the walker one node
        logic    use_anchor;  // compare against the anchor, not the key
        logic    found_latch; // record the matching node and its neighbours
        logic    alloc;       // record the lowest free slot
        logic    ins_write;   // write the new node and bookkeeping
        logic    ins_link;    // patch the link of the neighbouring node
        logic    del_exec;    // unlink the matched node
        logic    rd_emit;     // push the current entry to the output
        logic    resp_load;   // push a single status result
        status_t resp_code;
    } ukll_cmd_t;

    // datapath to controller status
    typedef struct packed {
        op_t  op;
        logic walk_end;
        logic walk_hit;
        logic free_any;
        logic need_link;
        logic list_empty;
        logic rd_last;
        logic out_free;
    } ukll_stat_t;

endpackage

// File: rtl/ukll_ctrl.sv
// ----------------------------------------------------------------------------
// ukll_ctrl
// Command sequencer: walks, allocation, list updates and result pacing
// ----------------------------------------------------------------------------
module ukll_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ukll_pkg::ukll_stat_t stat,
    output ukll_pkg::ukll_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_DECODE    = 10'b00_0000_0010,
        S_FIND_KEY  = 10'b00_0000_0100,
        S_FIND_ANC  = 10'b00_0000_1000,
        S_ALLOC     = 10'b00_0001_0000,
        S_INS_WRITE = 10'b00_0010_0000,
        S_INS_LINK  = 10'b00_0100_0000,
        S_DELETE    = 10'b00_1000_0000,
        S_READ      = 10'b01_0000_0000,
        S_RESP      = 10'b10_0000_0000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    ukll_pkg::status_t   resp_reg;
    ukll_pkg::status_t   resp_next;
    logic                is_insert;
    logic                needs_anchor;

    assign is_insert    = (stat.op == ukll_pkg::OP_INS_HEAD)  ||
                          (stat.op == ukll_pkg::OP_INS_TAIL)  ||
                          (stat.op == ukll_pkg::OP_INS_AFTER) ||
                          (stat.op == ukll_pkg::OP_INS_BEFORE);
    assign needs_anchor = (stat.op == ukll_pkg::OP_INS_AFTER) ||
                          (stat.op == ukll_pkg::OP_INS_BEFORE);

    // state and pending status code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            resp_reg  <= ukll_pkg::ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

    // next state and command decode
    always_comb
    begin
        state_next    = state_reg;
        resp_next     = resp_reg;
        cmd           = '0;
        cmd.resp_code = resp_reg;
        s_tready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load       = 1'b1;
                    cmd.walk_start = 1'b1;
                    state_next     = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (stat.op == ukll_pkg::OP_READ)
                begin
                    if (stat.list_empty)
                    begin
                        resp_next  = ukll_pkg::ST_EMPTY;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
                else if (is_insert || (stat.op == ukll_pkg::OP_DELETE))
                begin
                    state_next = S_FIND_KEY;
                end
                else
                begin
                    resp_next  = ukll_pkg::ST_DONE;
                    state_next = S_RESP;
                end
            end
            S_FIND_KEY:
            begin
                priority if (stat.walk_end)
                begin
                    priority if (stat.op == ukll_pkg::OP_DELETE)
                    begin
                        resp_next  = ukll_pkg::ST_ABSENT;
                        state_next = S_RESP;
                    end
                    else if (needs_anchor)
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = S_FIND_ANC;
                    end
                    else
                    begin
                        state_next = S_ALLOC;
                    end
                end
                else if (stat.walk_hit)
                begin
                    cmd.found_latch = 1'b1;
                    if (stat.op == ukll_pkg::OP_DELETE)
                    begin
                        state_next = S_DELETE;
                    end
                    else
                    begin
                        resp_next  = ukll_pkg::ST_DUP;
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_FIND_ANC:
            begin
                cmd.use_anchor = 1'b1;
                priority if (stat.walk_end)
                begin
                    resp_next  = ukll_pkg::ST_ABSENT;
                    state_next = S_RESP;
                end
                else if (stat.walk_hit)
                begin
                    cmd.found_latch = 1'b1;
                    state_next      = S_ALLOC;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_ALLOC:
            begin
                if (stat.free_any)
                begin
                    cmd.alloc  = 1'b1;
                    state_next = S_INS_WRITE;
                end
                else
                begin
                    resp_next  = ukll_pkg::ST_FULL;
                    state_next = S_RESP;
                end
            end
            S_INS_WRITE:
            begin
                cmd.ins_write = 1'b1;
                resp_next     = ukll_pkg::ST_DONE;
                state_next    = stat.need_link ? S_INS_LINK : S_RESP;
            end
            S_INS_LINK:
            begin
                cmd.ins_link = 1'b1;
                state_next   = S_RESP;
            end
            S_DELETE:
            begin
                cmd.del_exec = 1'b1;
                resp_next    = ukll_pkg::ST_DONE;
                state_next   = S_RESP;
            end
            S_READ:
            begin
                if (stat.out_free)
                begin
                    cmd.rd_emit = 1'b1;
                    if (stat.rd_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/ukll_datapath.sv
// ----------------------------------------------------------------------------
// ukll_datapath
// Node store, list pointers, walker, free-slot search and result register
// ----------------------------------------------------------------------------
`include "unique_key_linked_list_assert.svh"

module ukll_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [63:0]          s_tdata,
    input  logic [2:0]           s_tuser,
    output logic [31:0]          m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  ukll_pkg::ukll_cmd_t  cmd,
    output ukll_pkg::ukll_stat_t stat
);

    // node store
    ukll_pkg::key_t  keys_mem  [ukll_pkg::CAPACITY];
    ukll_pkg::slot_t links_mem [ukll_pkg::CAPACITY];

    // list bookkeeping
    logic [ukll_pkg::CAPACITY-1:0] used_reg, used_next;
    ukll_pkg::slot_t   head_reg, head_next;
    ukll_pkg::slot_t   tail_reg, tail_next;
    ukll_pkg::count_t  count_reg, count_next;

    // captured item
    ukll_pkg::op_t     op_reg;
    ukll_pkg::key_t    key_reg;
    ukll_pkg::key_t    anchor_reg;

    // walker and search results
    ukll_pkg::slot_t   cur_reg;
    ukll_pkg::slot_t   prev_reg;
    ukll_pkg::count_t  idx_reg;
    ukll_pkg::slot_t   found_at_reg;
    ukll_pkg::slot_t   found_prev_reg;
    ukll_pkg::slot_t   found_next_reg;
    ukll_pkg::slot_t   free_slot_reg;

    // result register
    logic              out_valid_reg;
    ukll_pkg::status_t out_status_reg;
    ukll_pkg::key_t    out_value_reg;
    logic              out_last_reg;

    ukll_pkg::key_t    rd_key;
    ukll_pkg::slot_t   rd_link;
    ukll_pkg::key_t    target;
    ukll_pkg::slot_t   free_idx;
    logic              free_any;
    logic              out_free;
    logic              rd_last;
    logic              list_empty;
    logic              link_we;
    ukll_pkg::slot_t   link_waddr;
    ukll_pkg::slot_t   link_wdata;

    // single read address into the store
    assign rd_key  = keys_mem[cur_reg];
    assign rd_link = links_mem[cur_reg];

    assign target     = cmd.use_anchor ? anchor_reg : key_reg;
    assign list_empty = (count_reg == '0);
    assign rd_last    = (ukll_pkg::count_t'(idx_reg + 1'b1) == count_reg);
    assign out_free   = !out_valid_reg || m_tready;

    // lowest free slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ukll_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_any = 1'b1;
                free_idx = ukll_pkg::slot_t'(i);
            end
        end
    end

    // status to the controller
    always_comb
    begin
        stat            = '0;
        stat.op         = op_reg;
        stat.walk_end   = (idx_reg == count_reg);
        stat.walk_hit   = (rd_key == target);
        stat.free_any   = free_any;
        stat.list_empty = list_empty;
        stat.rd_last    = rd_last;
        stat.out_free   = out_free;
        stat.need_link  = !list_empty &&
                          ((op_reg == ukll_pkg::OP_INS_TAIL)  ||
                           (op_reg == ukll_pkg::OP_INS_AFTER) ||
                           ((op_reg == ukll_pkg::OP_INS_BEFORE) &&
                            (found_at_reg != head_reg)));
    end

    // link write port select
    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = free_slot_reg;
        link_wdata = '0;
        priority if (cmd.ins_write)
        begin
            link_we    = 1'b1;
            link_waddr = free_slot_reg;
            if (!list_empty)
            begin
                priority if (op_reg == ukll_pkg::OP_INS_HEAD)
                    link_wdata = head_reg;
                else if (op_reg == ukll_pkg::OP_INS_AFTER)
                    link_wdata = found_next_reg;
                else if (op_reg == ukll_pkg::OP_INS_BEFORE)
                    link_wdata = found_at_reg;
                else
                    link_wdata = '0;
            end
        end
        else if (cmd.ins_link)
        begin
            link_we    = 1'b1;
            link_wdata = free_slot_reg;
            priority if (op_reg == ukll_pkg::OP_INS_TAIL)
                link_waddr = tail_reg;
            else if (op_reg == ukll_pkg::OP_INS_AFTER)
                link_waddr = found_at_reg;
            else
                link_waddr = found_prev_reg;
        end
        else if (cmd.del_exec && (found_at_reg != head_reg))
        begin
            link_we    = 1'b1;
            link_waddr = found_prev_reg;
            link_wdata = found_next_reg;
        end
    end

    // head, tail, count and used map updates
    always_comb
    begin
        used_next  = used_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        priority if (cmd.ins_write)
        begin
            used_next[free_slot_reg] = 1'b1;
            count_next               = ukll_pkg::count_t'(count_reg + 1'b1);
            priority if (list_empty)
            begin
                head_next = free_slot_reg;
                tail_next = free_slot_reg;
            end
            else if (op_reg == ukll_pkg::OP_INS_HEAD)
                head_next = free_slot_reg;
            else if ((op_reg == ukll_pkg::OP_INS_AFTER) && (found_at_reg == tail_reg))
                tail_next = free_slot_reg;
            else if ((op_reg == ukll_pkg::OP_INS_BEFORE) && (found_at_reg == head_reg))
                head_next = free_slot_reg;
            else
                head_next = head_reg;
        end
        else if (cmd.ins_link)
        begin
            if (op_reg == ukll_pkg::OP_INS_TAIL)
                tail_next = free_slot_reg;
        end
        else if (cmd.del_exec)
        begin
            used_next[found_at_reg] = 1'b0;
            count_next              = ukll_pkg::count_t'(count_reg - 1'b1);
            priority if (count_reg == ukll_pkg::count_t'(1))
            begin
                head_next = '0;
                tail_next = '0;
            end
            else if (found_at_reg == head_reg)
                head_next = found_next_reg;
            else if (found_at_reg == tail_reg)
                tail_next = found_prev_reg;
            else
                head_next = head_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg  <= used_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cmd.rd_emit || cmd.resp_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // node store writes
    always_ff @(posedge clk)
    begin
        if (cmd.ins_write)
            keys_mem[free_slot_reg] <= key_reg;
        if (link_we)
            links_mem[link_waddr] <= link_wdata;
    end

    // item capture, walker and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= s_tuser;
            key_reg    <= s_tdata[31:0];
            anchor_reg <= s_tdata[63:32];
        end
        if (cmd.walk_start)
        begin
            cur_reg  <= head_reg;
            prev_reg <= head_reg;
            idx_reg  <= '0;
        end
        else if (cmd.walk_step)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= rd_link;
            idx_reg  <= ukll_pkg::count_t'(idx_reg + 1'b1);
        end
        else if (cmd.rd_emit)
        begin
            cur_reg <= rd_link;
            idx_reg <= ukll_pkg::count_t'(idx_reg + 1'b1);
        end
        if (cmd.found_latch)
        begin
            found_at_reg   <= cur_reg;
            found_prev_reg <= prev_reg;
            found_next_reg <= rd_link;
        end
        if (cmd.alloc)
            free_slot_reg <= free_idx;
        if (cmd.rd_emit)
        begin
            out_status_reg <= ukll_pkg::ST_DONE;
            out_value_reg  <= rd_key;
            out_last_reg   <= rd_last;
        end
        else if (cmd.resp_load)
        begin
            out_status_reg <= cmd.resp_code;
            out_value_reg  <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // consistency checks
    `UKLL_ASSERT_IMPL(a_count_matches_used, 1'b1,
        $countones(used_reg) == int'(count_reg), "entry count disagrees with used map")
    `UKLL_ASSERT_IMPL(a_empty_pointers, list_empty,
        (head_reg == '0) && (tail_reg == '0), "empty list with non-zero head or tail")
    `UKLL_ASSERT_IMPL(a_no_overwrite, cmd.rd_emit || cmd.resp_load,
        out_free, "result loaded over an untaken transfer")
    `UKLL_ASSERT_NEXT(a_insert_grows, cmd.ins_write,
        count_reg == ukll_pkg::count_t'($past(count_reg) + 1'b1), "insert did not grow count")

endmodule

// File: rtl/unique_key_linked_list.sv
// ----------------------------------------------------------------------------
// unique_key_linked_list
// Ordered list of distinct signed keys held in a fixed pool of linked nodes
// ----------------------------------------------------------------------------
// One command is taken at a time; s_tready is high only while the block is
// idle. An insert or delete passes through a capture and decode state, a walk
// over list nodes (the key search, then for insert after or before the anchor
// search, each visiting every entry at most once), then for inserts an
// allocation state and one or two store writes, or for delete an unlink, and
// a result state; the walks use the single read port of the node store.
// Read out gives one transfer per entry at one per cycle while
// m_tready stays high; the final transfer of every command carries tlast.
// The next command is accepted in the cycle after its last result is loaded
// into the output register, even if that result has not yet been taken.
// ----------------------------------------------------------------------------
module unique_key_linked_list (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key [31:0], anchor [63:32]
    input  logic [2:0]  s_tuser,   // cmd [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // entry_value [31:0]
    output logic [2:0]  m_tuser,   // status [2:0]
    output logic        m_tlast
);

    ukll_pkg::ukll_cmd_t  cmd;
    ukll_pkg::ukll_stat_t stat;

    // sequencer
    ukll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store and result path
    ukll_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the unique-key linked list block
// ----------------------------------------------------------------------------
// A short table of commands walks the list through its corner cases: empty
// read out, absent keys and anchors, duplicates, extreme keys, head and tail
// moves, unused command codes. Random command streams follow, alternating
// between a growing mode that runs the store up to full and a shrinking mode
// that drains it. Every accepted command is applied to a behavioural copy of
// the list, and every result transfer is scored in order against it or, for the fixed table rows, the typed status.
// ----------------------------------------------------------------------------
module tb;

    // one expected result transfer
    typedef struct packed {
        ukll_pkg::status_t status;
        ukll_pkg::key_t    value;
        logic              last;
    } reply_t;

    // one row of the directed table
    typedef struct packed {
        ukll_pkg::op_t     op;
        ukll_pkg::key_t    key;
        ukll_pkg::key_t    anchor;
        logic              fixed;
        ukll_pkg::status_t status;
    } plan_row_t;

    // command codes the block ignores
    localparam ukll_pkg::op_t OP_UNUSED_A = 3'd6;
    localparam ukll_pkg::op_t OP_UNUSED_B = 3'd7;

    localparam ukll_pkg::op_t  INSERT_OPS [4] = '{ukll_pkg::OP_INS_HEAD,
                                                  ukll_pkg::OP_INS_TAIL,
                                                  ukll_pkg::OP_INS_AFTER,
                                                  ukll_pkg::OP_INS_BEFORE};
    localparam ukll_pkg::key_t KEY_MIN        = 32'sh8000_0000;
    localparam ukll_pkg::key_t KEY_MAX        = 32'sh7FFF_FFFF;
    localparam ukll_pkg::key_t KEY_ZERO       = 32'sh0000_0000;
    localparam ukll_pkg::key_t KEY_NEG1       = 32'shFFFF_FFFF;
    localparam int             PHASE_ITEMS    = 100;
    localparam int             LONG_HOLD      = 400;
    localparam int             DRAIN_CYCLES   = 2 * ukll_pkg::CAPACITY + 16;

    // corner cases first; status typed in only for the obvious rows
    localparam int        PLAN_LEN = 21;
    localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
        '{ukll_pkg::OP_READ,       KEY_ZERO,  KEY_ZERO,   1'b1, ukll_pkg::ST_EMPTY},
        '{ukll_pkg::OP_DELETE,     32'sd5,    KEY_ZERO,   1'b1, ukll_pkg::ST_ABSENT},
        '{ukll_pkg::OP_INS_AFTER,  32'sd1,    32'sd7,     1'b1, ukll_pkg::ST_ABSENT},
        '{ukll_pkg::OP_INS_HEAD,   KEY_MIN,   KEY_ZERO,   1'b1, ukll_pkg::ST_DONE},
        '{ukll_pkg::OP_INS_TAIL,   KEY_MAX,   KEY_ZERO,   1'b1, ukll_pkg::ST_DONE},
        '{ukll_pkg::OP_INS_HEAD,   KEY_MIN,   KEY_ZERO,   1'b1, ukll_pkg::ST_DUP},
        '{ukll_pkg::OP_INS_AFTER,  KEY_ZERO,  KEY_MIN,    1'b0, ukll_pkg::ST_DONE},
        '{ukll_pkg::OP_INS_BEFORE, KEY_NEG1,  KEY_MAX,    1'b0, ukll_pkg::ST_DONE},
        '{ukll_pkg::OP_INS_BEFORE, 32'sd5,    KEY_MIN,    1'b0, ukll_pkg::ST_DONE},
        '{ukll_pkg::OP_INS_AFTER,  32'sd6,    KEY_MAX,    1'b0, ukll_pkg::ST_DONE},
        '{ukll_pkg::OP_READ,       KEY_ZERO,  KEY_ZERO,   1'b0, ukll_pkg::ST_DONE},
        '{ukll_pkg::OP_INS_BEFORE, 32'sd9,    32'sd1234,  1'b1, ukll_pkg::ST_ABSENT},
        '{ukll_pkg::OP_INS_AFTER,  KEY_ZERO,  32'sd1234,  1'b1, ukll_pkg::ST_DUP},
        '{ukll_pkg::OP_DELETE,     32'sd6,    KEY_ZERO,   1'b0, ukll_pkg::ST_DONE},
        '{ukll_pkg::OP_INS_TAIL,   32'sd10,   KEY_ZERO,   1'b0, ukll_pkg::ST_DONE},
        '{ukll_pkg::OP_DELETE,     32'sd5,    KEY_ZERO,   1'b0, ukll_pkg::ST_DONE},
        '{ukll_pkg::OP_DELETE,     KEY_NEG1,  KEY_ZERO,   1'b0, ukll_pkg::ST_DONE},
        '{ukll_pkg::OP_DELETE,     32'sd77,   KEY_ZERO,   1'b1, ukll_pkg::ST_ABSENT},
        '{OP_UNUSED_A,             KEY_MAX,   KEY_MIN,    1'b1, ukll_pkg::ST_DONE},
        '{OP_UNUSED_B,             KEY_NEG1,  KEY_NEG1,   1'b1, ukll_pkg::ST_DONE},
        '{ukll_pkg::OP_READ,       KEY_ZERO,  KEY_ZERO,   1'b0, ukll_pkg::ST_DONE}
    };

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;     // key [31:0], anchor [63:32]
    logic [2:0]  s_tuser  = '0;     // cmd [2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // entry_value [31:0]
    logic [2:0]  m_tuser;           // status [2:0]
    logic        m_tlast;

    // behavioural copy of the list
    ukll_pkg::key_t   list_key  [ukll_pkg::CAPACITY];
    ukll_pkg::slot_t  list_link [ukll_pkg::CAPACITY];
    bit               slot_busy [ukll_pkg::CAPACITY];
    ukll_pkg::slot_t  list_head = '0;
    ukll_pkg::slot_t  list_tail = '0;
    int               list_len  = 0;

    reply_t list_replies_due [$];
    reply_t new_replies      [$];

    int     mismatches    = 0;
    int     send_idle_pct = 12;
    int     recv_idle_pct = 75;
    bit     hold_request  = 1'b0;
    int     hold_left     = 0;
    bit     growing       = 1'b1;

    unique_key_linked_list i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic reply_t status_only(ukll_pkg::status_t code);
        return '{code, KEY_ZERO, 1'b1};
    endfunction

    // walk the list for a key; gives its slot and the slot ahead of it
    function automatic bit locate_key(ukll_pkg::key_t k, output ukll_pkg::slot_t at,
                                      output ukll_pkg::slot_t prev);
        ukll_pkg::slot_t cur;
        cur  = list_head;
        prev = list_head;
        at   = '0;
        for (int i = 0; i < list_len; i++)
        begin
            if (list_key[cur] == k)
            begin
                at = cur;
                return 1'b1;
            end
            prev = cur;
            cur  = list_link[cur];
        end
        return 1'b0;
    endfunction

    // apply one command to the list copy, leaving its results in new_replies
    function automatic void list_command_effect(ukll_pkg::op_t op, ukll_pkg::key_t key,
                                                ukll_pkg::key_t anchor);
        ukll_pkg::slot_t at, prev, a_at, a_prev, fresh, cur;
        bit              got_slot;
        new_replies.delete();
        at = '0; prev = '0; a_at = '0; a_prev = '0; fresh = '0;
        if (op == ukll_pkg::OP_READ)
        begin
            if (list_len == 0)
            begin
                new_replies.push_back(status_only(ukll_pkg::ST_EMPTY));
                return;
            end
            cur = list_head;
            for (int i = 0; i < list_len; i++)
            begin
                new_replies.push_back('{ukll_pkg::ST_DONE, list_key[cur], i == list_len - 1});
                cur = list_link[cur];
            end
            return;
        end
        if (op == ukll_pkg::OP_DELETE)
        begin
            if (!locate_key(key, at, prev))
            begin
                new_replies.push_back(status_only(ukll_pkg::ST_ABSENT));
                return;
            end
            if (at == list_head)
                list_head = list_link[at];
            else
            begin
                list_link[prev] = list_link[at];
                if (at == list_tail)
                    list_tail = prev;
            end
            slot_busy[at] = 1'b0;
            list_len--;
            if (list_len == 0)
            begin
                list_head = '0;
                list_tail = '0;
            end
            new_replies.push_back(status_only(ukll_pkg::ST_DONE));
            return;
        end
        if (op > ukll_pkg::OP_READ)
        begin
            new_replies.push_back(status_only(ukll_pkg::ST_DONE));
            return;
        end
        // inserts: duplicate, then anchor, then a free slot
        if (locate_key(key, at, prev))
        begin
            new_replies.push_back(status_only(ukll_pkg::ST_DUP));
            return;
        end
        if ((op == ukll_pkg::OP_INS_AFTER || op == ukll_pkg::OP_INS_BEFORE) &&
            !locate_key(anchor, a_at, a_prev))
        begin
            new_replies.push_back(status_only(ukll_pkg::ST_ABSENT));
            return;
        end
        got_slot = 1'b0;
        for (int s = 0; s < ukll_pkg::CAPACITY; s++)
        begin
            if (!got_slot && !slot_busy[s])
            begin
                fresh    = ukll_pkg::slot_t'(s);
                got_slot = 1'b1;
            end
        end
        if (!got_slot)
        begin
            new_replies.push_back(status_only(ukll_pkg::ST_FULL));
            return;
        end
        slot_busy[fresh] = 1'b1;
        list_key[fresh]  = key;
        list_link[fresh] = '0;
        if (list_len == 0)
        begin
            list_head = fresh;
            list_tail = fresh;
        end
        else if (op == ukll_pkg::OP_INS_HEAD)
        begin
            list_link[fresh] = list_head;
            list_head        = fresh;
        end
        else if (op == ukll_pkg::OP_INS_TAIL)
        begin
            list_link[list_tail] = fresh;
            list_tail            = fresh;
        end
        else if (op == ukll_pkg::OP_INS_AFTER)
        begin
            list_link[fresh] = list_link[a_at];
            list_link[a_at]  = fresh;
            if (a_at == list_tail)
                list_tail = fresh;
        end
        else
        begin
            list_link[fresh] = a_at;
            if (a_at == list_head)
                list_head = fresh;
            else
                list_link[a_prev] = fresh;
        end
        list_len++;
        new_replies.push_back(status_only(ukll_pkg::ST_DONE));
    endfunction

    // any key, now and then one of the extremes
    function automatic ukll_pkg::key_t any_key();
        int pick;
        pick = $urandom_range(39);
        unique case (pick)
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return KEY_ZERO;
            3:       return KEY_NEG1;
            default: return ukll_pkg::key_t'($urandom);
        endcase
    endfunction

    // a key currently held in the list, or any key if it is empty
    function automatic ukll_pkg::key_t stored_key();
        ukll_pkg::slot_t cur;
        int              hops;
        if (list_len == 0)
            return any_key();
        cur  = list_head;
        hops = $urandom_range(list_len - 1);
        repeat (hops)
            cur = list_link[cur];
        return list_key[cur];
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // offer one command, wait for its transfer, then book its results
    task automatic send_command(ukll_pkg::op_t op, ukll_pkg::key_t key,
                                ukll_pkg::key_t anchor, logic fixed,
                                ukll_pkg::status_t status);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {anchor, key};
        do
            @(posedge clk);
        while (!s_tready);
        list_command_effect(op, key, anchor);
        if (fixed)
            list_replies_due.push_back(status_only(status));
        else
            foreach (new_replies[i])
                list_replies_due.push_back(new_replies[i]);
        // random gap on the sending side
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // one random command, shaped by the growing or shrinking mode
    task automatic random_command(output bit counted);
        ukll_pkg::op_t  op;
        ukll_pkg::key_t key;
        ukll_pkg::key_t anchor;
        int             pick;
        pick = $urandom_range(99);
        if (growing)
            op = (pick < 72) ? INSERT_OPS[pick % 4] :
                 (pick < 82) ? ukll_pkg::OP_DELETE :
                 (pick < 95) ? ukll_pkg::OP_READ :
                 (pick < 97) ? OP_UNUSED_A : OP_UNUSED_B;
        else
            op = (pick < 55) ? ukll_pkg::OP_DELETE :
                 (pick < 80) ? INSERT_OPS[pick % 4] :
                 (pick < 95) ? ukll_pkg::OP_READ :
                 (pick < 97) ? OP_UNUSED_A : OP_UNUSED_B;
        if (op == ukll_pkg::OP_DELETE)
            key = ($urandom_range(99) < 85) ? stored_key() : any_key();
        else if (op <= ukll_pkg::OP_INS_BEFORE)
            key = ($urandom_range(99) < 80) ? any_key() : stored_key();
        else
            key = any_key();
        anchor = ($urandom_range(99) < 85) ? stored_key() : any_key();
        send_command(op, key, anchor, 1'b0, ukll_pkg::ST_DONE);
        counted = (op <= ukll_pkg::OP_READ);
        // switch mode once the store has refused an insert as full, or has emptied
        if (growing && new_replies[0].status == ukll_pkg::ST_FULL)
            growing = 1'b0;
        else if (!growing && list_len == 0)
            growing = 1'b1;
    endtask

    // result side: score each transfer and drive tready
    initial
    begin
        reply_t want;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (list_replies_due.size() == 0)
                    report_mismatch("unexpected result", m_tdata, '0);
                else
                begin
                    want = list_replies_due.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata !== want.value)
                        report_mismatch("entry_value", m_tdata, want.value);
                    if (m_tlast !== want.last)
                        report_mismatch("last", 32'(m_tlast), 32'(want.last));
                end
            end
            // long hold-off on request, else random stalls
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD - 1;
                m_tready     <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // stimulus
    initial
    begin
        int  sent;
        bit  counted;
        foreach (slot_busy[i])
            slot_busy[i] = 1'b0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < PLAN_LEN; r++)
            send_command(DIRECTED_PLAN[r].op, DIRECTED_PLAN[r].key,
                         DIRECTED_PLAN[r].anchor, DIRECTED_PLAN[r].fixed,
                         DIRECTED_PLAN[r].status);

        // random streams under three idling patterns
        for (int phase = 0; phase < 3; phase++)
        begin
            unique case (phase)
                0:
                begin
                    send_idle_pct = 12;
                    recv_idle_pct = 75;
                end
                1:
                begin
                    send_idle_pct = 75;
                    recv_idle_pct = 12;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_request  = 1'b1;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                random_command(counted);
                if (counted)
                    sent++;
            end
        end
        s_tvalid <= 1'b0;

        // drain
        while (list_replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: unique_key_linked_list.f
+incdir+rtl
rtl/ukll_pkg.sv
rtl/ukll_ctrl.sv
rtl/ukll_datapath.sv
rtl/unique_key_linked_list.sv
verif/tb.sv
